### sv/smrp_pkg.sv
// Shared types and constants of the spectrum magnitude, RMS and peak block.
package smrp_pkg;

	localparam int BINS_DEFAULT = 512;

	localparam int SAMPLE_W  = 16;
	localparam int EXP_W     = 4;
	localparam int INDEX_W   = 9;
	localparam int MAG_W     = 16;
	localparam int SQUARE_W  = 2 * SAMPLE_W;
	localparam int POWER_W   = 52;
	localparam int QUAD_SHIFT = 4;
	localparam int QUAD_W    = POWER_W - QUAD_SHIFT;
	localparam int SUM_W     = 57;
	localparam int MAG_SHIFT = 5;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// Square root unit: one result bit per cycle.
	localparam int ROOT_W = QUAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_RE,
		S_MUL_IM,
		S_ADD,
		S_SUM,
		S_SQ_MAG,
		S_SQ_RMS,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [QUAD_W-1:0] operand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

### sv/smrp_isqrt.sv
// Bit-serial floor square root of a 48-bit value, one root bit per cycle.
module smrp_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  smrp_pkg::sqrt_req_t req,
	output smrp_pkg::sqrt_rsp_t rsp
);

	localparam int QuadW = smrp_pkg::QUAD_W;
	localparam int RootW = smrp_pkg::ROOT_W;
	localparam int RemW  = smrp_pkg::REM_W;
	localparam int IterW = smrp_pkg::ITER_W;
	localparam logic [IterW-1:0] LastIter = IterW'(RootW - 1);

	logic [QuadW-1:0] rad_q;
	logic [RemW-1:0]  rem_q;
	logic [RootW-1:0] root_q;
	logic [IterW-1:0] iter_q;
	logic             run_q;
	logic             done_q;

	logic [RemW-1:0] rem_sh;
	logic [RemW-1:0] trial;
	logic            fits;

	// The remainder never exceeds twice the partial root, so its top two bits are zero.
	always_comb begin
		rem_sh = {rem_q[RemW-3:0], rad_q[QuadW-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (run_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == LastIter) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[QuadW-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RootW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

### sv/spectrum_magnitude_rms_peak.sv
// Top level: bin magnitude, block RMS and peak detector with a shared square root unit.
//
//  Channel  Direction  Signals                          Content
//  s_*      in         s_tvalid s_tready s_tdata[39:0]  one FFT bin and its block exponent
//  m_*      out        m_tvalid m_tready m_tdata[71:0]  one bin result; m_tlast on block end
//                      m_tlast
//
// An ordinary bin runs from acceptance until the next bin can be accepted through
// squaring and summing on the single 16x16 multiplier (S_MUL_RE, S_MUL_IM, S_ADD,
// S_SUM), the bit-serial square root unit (24 root bits, then its done pulse), then
// S_OUT and S_IDLE. The last bin of a block runs the square root a second time for the
// RMS in S_SQ_RMS. arst_n clears the sequencer, the bin count, the running sum
// and the peak. A new bin is accepted while a result still waits on m_*; a finished
// result waits in S_OUT until the output register is free.
module spectrum_magnitude_rms_peak #(
	parameter int BINS = smrp_pkg::BINS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// bin_re[15:0], bin_im[31:16], block_exp[35:32], zero padding [39:36]
	input  logic [smrp_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// bin_index[8:0], magnitude[24:9], rms_value[40:25], peak_value[56:41],
	// peak_index[65:57], zero padding [71:66]
	output logic [smrp_pkg::OUT_DATA_W-1:0] m_tdata,
	// block_done
	output logic                            m_tlast
);

	localparam int SampleW = smrp_pkg::SAMPLE_W;
	localparam int ExpW    = smrp_pkg::EXP_W;
	localparam int IndexW  = smrp_pkg::INDEX_W;
	localparam int MagW    = smrp_pkg::MAG_W;
	localparam int SquareW = smrp_pkg::SQUARE_W;
	localparam int PowerW  = smrp_pkg::POWER_W;
	localparam int QuadW   = smrp_pkg::QUAD_W;
	localparam int SumW    = smrp_pkg::SUM_W;
	localparam int RootW   = smrp_pkg::ROOT_W;
	localparam int ShiftW  = SquareW + 2 * ((1 << ExpW) - 1);
	localparam int CntW    = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int Log2Bins = $clog2(BINS + 1) - 1;
	localparam logic [CntW-1:0] LastBin = CntW'(BINS - 1);

	smrp_pkg::state_t state_q, state_d;

	logic [SampleW-1:0] abs_re_q, abs_im_q;
	logic [ExpW-1:0]    exp_q;
	logic [SquareW-1:0] prod_q;
	logic [PowerW-1:0]  pow_q;
	logic [QuadW-1:0]   quad_q;
	logic [SumW-1:0]    sum_q;
	logic [CntW-1:0]    count_q;
	logic [MagW-1:0]    best_q;
	logic [IndexW-1:0]  best_idx_q;
	logic [MagW-1:0]    mag_q;
	logic [MagW-1:0]    rms_q;

	logic               out_valid_q;
	logic [IndexW-1:0]  o_idx_q;
	logic [MagW-1:0]    o_mag_q;
	logic               o_done_q;
	logic [MagW-1:0]    o_rms_q;
	logic [MagW-1:0]    o_pv_q;
	logic [IndexW-1:0]  o_pi_q;

	smrp_pkg::sqrt_req_t sq_req;
	smrp_pkg::sqrt_rsp_t sq_rsp;

	logic               accept;
	logic               out_free;
	logic               last_bin;
	logic [SampleW-1:0] in_re, in_im, abs_re, abs_im;
	logic [SampleW-1:0] mul_a;
	logic [SquareW-1:0] mul_p;
	logic [ShiftW-1:0]  prod_sh;
	logic [PowerW-1:0]  power_sum52;
	logic [31:0]        idx_wide;
	logic [IndexW-1:0]  idx_w;
	logic [RootW-1:0]   root_sh;
	logic [MagW-1:0]    root_mag;
	logic [SumW-1:0]    avg_sh;

	smrp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// Magnitudes of the two's complement parts; the most negative value maps to 0x8000.
	always_comb begin
		in_re  = s_tdata[SampleW-1:0];
		in_im  = s_tdata[2*SampleW-1:SampleW];
		abs_re = in_re[SampleW-1] ? (~in_re + 1'b1) : in_re;
		abs_im = in_im[SampleW-1] ? (~in_im + 1'b1) : in_im;
	end

	always_comb begin
		accept   = s_tvalid && s_tready;
		out_free = !out_valid_q || m_tready;
		last_bin = (count_q == LastBin);
		idx_wide = 32'(LastBin) - 32'(count_q);
		idx_w    = idx_wide[IndexW-1:0];
		// (a << e)^2 equals a^2 << 2e; only the low 52 bits survive the mask.
		mul_a       = (state_q == smrp_pkg::S_MUL_RE) ? abs_re_q : abs_im_q;
		mul_p       = {{SampleW{1'b0}}, mul_a} * {{SampleW{1'b0}}, mul_a};
		prod_sh     = {{(ShiftW-SquareW){1'b0}}, prod_q} << {exp_q, 1'b0};
		power_sum52 = pow_q + prod_sh[PowerW-1:0];
		root_sh     = sq_rsp.root >> smrp_pkg::MAG_SHIFT;
		root_mag    = root_sh[MagW-1:0];
		avg_sh      = sum_q >> Log2Bins;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smrp_pkg::S_IDLE:   if (accept) state_d = smrp_pkg::S_MUL_RE;
			smrp_pkg::S_MUL_RE: state_d = smrp_pkg::S_MUL_IM;
			smrp_pkg::S_MUL_IM: state_d = smrp_pkg::S_ADD;
			smrp_pkg::S_ADD:    state_d = smrp_pkg::S_SUM;
			smrp_pkg::S_SUM:    state_d = smrp_pkg::S_SQ_MAG;
			smrp_pkg::S_SQ_MAG: begin
				if (sq_rsp.done) state_d = last_bin ? smrp_pkg::S_SQ_RMS : smrp_pkg::S_OUT;
			end
			smrp_pkg::S_SQ_RMS: if (sq_rsp.done) state_d = smrp_pkg::S_OUT;
			smrp_pkg::S_OUT:    if (out_free) state_d = smrp_pkg::S_IDLE;
			default:            state_d = smrp_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready       = 1'b0;
		sq_req.start   = 1'b0;
		sq_req.operand = quad_q;
		unique case (state_q)
			smrp_pkg::S_IDLE: s_tready = 1'b1;
			smrp_pkg::S_SUM:  sq_req.start = 1'b1;
			smrp_pkg::S_SQ_MAG: begin
				sq_req.start   = sq_rsp.done && last_bin;
				sq_req.operand = avg_sh[QuadW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smrp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Block state: bin count, running sum and peak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else begin
			unique case (state_q)
				smrp_pkg::S_SUM: sum_q <= sum_q + SumW'(quad_q);
				smrp_pkg::S_SQ_MAG: begin
					if (sq_rsp.done && (root_mag > best_q)) begin
						best_q     <= root_mag;
						best_idx_q <= idx_w;
					end
				end
				smrp_pkg::S_OUT: begin
					if (out_free) begin
						if (last_bin) begin
							count_q    <= '0;
							sum_q      <= '0;
							best_q     <= '0;
							best_idx_q <= '0;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current bin.
	always_ff @(posedge clk) begin
		if (accept) begin
			abs_re_q <= abs_re;
			abs_im_q <= abs_im;
			exp_q    <= s_tdata[2*SampleW+ExpW-1:2*SampleW];
		end
		if (state_q == smrp_pkg::S_MUL_RE || state_q == smrp_pkg::S_MUL_IM) begin
			prod_q <= mul_p;
		end
		if (state_q == smrp_pkg::S_MUL_IM) begin
			pow_q <= prod_sh[PowerW-1:0];
		end
		if (state_q == smrp_pkg::S_ADD) begin
			quad_q <= power_sum52[PowerW-1:smrp_pkg::QUAD_SHIFT];
		end
		if (state_q == smrp_pkg::S_SQ_MAG && sq_rsp.done) begin
			mag_q <= root_mag;
		end
		if (state_q == smrp_pkg::S_SQ_RMS && sq_rsp.done) begin
			rms_q <= root_mag;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == smrp_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == smrp_pkg::S_OUT && out_free) begin
			o_idx_q  <= idx_w;
			o_mag_q  <= mag_q;
			o_done_q <= last_bin;
			o_rms_q  <= last_bin ? rms_q : '0;
			o_pv_q   <= last_bin ? best_q : '0;
			o_pi_q   <= last_bin ? best_idx_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = o_done_q;
	assign m_tdata  = {{(smrp_pkg::OUT_DATA_W - 2*IndexW - 3*MagW){1'b0}},
	                   o_pi_q, o_pv_q, o_rms_q, o_mag_q, o_idx_q};

endmodule

### tb/spectrum_magnitude_rms_peak_tb.sv
// Self-checking testbench for the spectrum magnitude, RMS and peak block.
module spectrum_magnitude_rms_peak_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The block runs at its default length, so one block end falls inside the run.
	localparam int BINS = smrp_pkg::BINS_DEFAULT;
	localparam int BINS_LOG2 = $clog2(BINS + 1) - 1;
	localparam int RANDOM_BINS = 538;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [smrp_pkg::SAMPLE_W-1:0] re;
		logic [smrp_pkg::SAMPLE_W-1:0] im;
		logic [smrp_pkg::EXP_W-1:0]    ex;
		logic                          drain;
	} bin_item_t;

	typedef struct packed {
		logic [smrp_pkg::INDEX_W-1:0] bin_index;
		logic [smrp_pkg::MAG_W-1:0]   magnitude;
		logic                         block_done;
		logic [smrp_pkg::MAG_W-1:0]   rms_value;
		logic [smrp_pkg::MAG_W-1:0]   peak_value;
		logic [smrp_pkg::INDEX_W-1:0] peak_index;
	} bin_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [smrp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [smrp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;

	spectrum_magnitude_rms_peak #(.BINS(BINS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	bin_item_t   pending_bins[$];
	bin_result_t expected_results[$];
	bin_item_t   bin_on_bus;
	bin_result_t seen_result;
	bin_result_t want_result;

	// Predictor state, mirroring what the block accumulates over one block.
	int unsigned                  pred_count;
	logic [smrp_pkg::SUM_W-1:0]   pred_power_sum;
	logic [smrp_pkg::MAG_W-1:0]   pred_best_value;
	logic [smrp_pkg::INDEX_W-1:0] pred_best_index;

	int unsigned error_count;
	int unsigned bins_sent;
	int unsigned results_seen;
	int unsigned blocks_seen;
	int unsigned quiet_cycles;
	int unsigned hold_left;
	logic        hold_done;
	logic        sender_idle;

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	function automatic logic [63:0] part_abs(logic [smrp_pkg::SAMPLE_W-1:0] v);
		return 64'(v[smrp_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v});
	endfunction

	// Floor square root by trial squaring, one result bit at a time.
	function automatic logic [23:0] floor_root(logic [47:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 23; i >= 0; i--) begin
			trial = root | (64'h1 << i);
			if (trial * trial <= {16'h0, v})
				root = trial;
		end
		return root[23:0];
	endfunction

	function automatic bin_result_t predict_bin(bin_item_t b);
		logic [63:0] re_abs;
		logic [63:0] im_abs;
		logic [63:0] squares;
		logic [47:0] quad;
		logic [smrp_pkg::SUM_W-1:0] avg;
		bin_result_t r;
		re_abs = part_abs(b.re) << b.ex;
		im_abs = part_abs(b.im) << b.ex;
		squares = re_abs * re_abs + im_abs * im_abs;
		quad = squares[51:4];
		r = '0;
		r.bin_index = smrp_pkg::INDEX_W'(BINS - 1 - pred_count);
		r.magnitude = smrp_pkg::MAG_W'(floor_root(quad) >> smrp_pkg::MAG_SHIFT);
		pred_power_sum = pred_power_sum + smrp_pkg::SUM_W'(quad);
		if (r.magnitude > pred_best_value) begin
			pred_best_value = r.magnitude;
			pred_best_index = r.bin_index;
		end
		if (pred_count >= BINS - 1) begin
			avg = pred_power_sum >> BINS_LOG2;
			r.block_done = 1'b1;
			r.rms_value = smrp_pkg::MAG_W'(floor_root(avg[47:0]) >> smrp_pkg::MAG_SHIFT);
			r.peak_value = pred_best_value;
			r.peak_index = pred_best_index;
			pred_count = 0;
			pred_power_sum = '0;
			pred_best_value = '0;
			pred_best_index = '0;
		end else begin
			pred_count++;
		end
		return r;
	endfunction

	task automatic add_bin(logic [smrp_pkg::SAMPLE_W-1:0] re,
			logic [smrp_pkg::SAMPLE_W-1:0] im, logic [smrp_pkg::EXP_W-1:0] ex);
		bin_item_t b;
		b.re = re;
		b.im = im;
		b.ex = ex;
		b.drain = 1'b0;
		pending_bins.push_back(b);
	endtask

	// The sender stops at this marker until every pending result has come back.
	task automatic add_drain();
		bin_item_t b;
		b = '0;
		b.drain = 1'b1;
		pending_bins.push_back(b);
	endtask

	function automatic logic [smrp_pkg::SAMPLE_W-1:0] random_part();
		logic [smrp_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = smrp_pkg::SAMPLE_W'($urandom);
			5, 6: v = smrp_pkg::SAMPLE_W'($urandom_range(511) - 256);
			7: v = smrp_pkg::SAMPLE_W'($urandom_range(4095) - 2048);
			default: begin
				case ($urandom_range(3))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					default: v = 16'hFFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	// Driver: offers bins from the pending queue and predicts each one accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				bins_sent++;
				expected_results.push_back(predict_bin(bin_on_bus));
			end
			sender_idle = ($urandom_range(99) < 6) && !(bins_sent >= 350 && bins_sent < 480);
			if (!s_tvalid || s_tready) begin
				if (pending_bins.size() != 0 && pending_bins[0].drain) begin
					if (expected_results.size() == 0)
						pending_bins.delete(0);
					s_tvalid <= 1'b0;
				end else if (pending_bins.size() != 0 && !sender_idle) begin
					bin_on_bus = pending_bins.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, bin_on_bus.ex, bin_on_bus.im, bin_on_bus.re};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result item and drives the output back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				seen_result.bin_index = m_tdata[8:0];
				seen_result.magnitude = m_tdata[24:9];
				seen_result.rms_value = m_tdata[40:25];
				seen_result.peak_value = m_tdata[56:41];
				seen_result.peak_index = m_tdata[65:57];
				seen_result.block_done = m_tlast;
				if (m_tlast)
					blocks_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no bin pending",
						results_seen));
				end else begin
					want_result = expected_results.pop_front();
					check_field("bin_index", seen_result.bin_index, want_result.bin_index);
					check_field("magnitude", seen_result.magnitude, want_result.magnitude);
					check_field("block_done", seen_result.block_done, want_result.block_done);
					check_field("rms_value", seen_result.rms_value, want_result.rms_value);
					check_field("peak_value", seen_result.peak_value, want_result.peak_value);
					check_field("peak_index", seen_result.peak_index, want_result.peak_index);
				end
			end
			// One long hold-off lets the block fill up and stall its input.
			if (results_seen == 100 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(($urandom_range(99) < 6) &&
					!(results_seen >= 350 && results_seen < 480));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Timeout: no item moved for %0d cycles", quiet_cycles);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		bin_item_t prev;
		logic [smrp_pkg::EXP_W-1:0] ex;

		pred_count = 0;
		pred_power_sum = '0;
		pred_best_value = '0;
		pred_best_index = '0;
		error_count = 0;
		bins_sent = 0;
		results_seen = 0;
		blocks_seen = 0;
		quiet_cycles = 0;

		// Extremes first: full-scale parts, large exponents whose square
		// overflows the 52-bit mask, and equal magnitudes back to back.
		add_bin(16'h8000, 16'h8000, 4'd0);
		add_bin(16'h7FFF, 16'h7FFF, 4'd0);
		add_bin(16'h0000, 16'h0000, 4'd0);
		add_bin(16'h8000, 16'h8000, 4'd15);
		add_bin(16'h7FFF, 16'h8000, 4'd10);
		add_bin(16'hFFFF, 16'h0001, 4'd11);
		add_bin(16'h0001, 16'hFFFF, 4'd12);
		add_bin(16'h8000, 16'h0000, 4'd13);
		add_bin(16'h0000, 16'h7FFF, 4'd14);
		add_bin(16'd12345, -16'sd12345, 4'd15);
		add_bin(16'h7FFF, 16'h8000, 4'd10);
		add_bin(16'h8000, 16'h7FFF, 4'd10);
		add_drain();

		prev = '0;
		for (int i = 0; i < RANDOM_BINS; i++) begin
			if ($urandom_range(7) == 0)
				ex = smrp_pkg::EXP_W'($urandom_range(15, 11));
			else
				ex = smrp_pkg::EXP_W'($urandom_range(10));
			// Now and then repeat a magnitude to exercise the first-wins rule.
			if ($urandom_range(9) == 0)
				add_bin(prev.im, prev.re, prev.ex);
			else begin
				prev.re = random_part();
				prev.im = random_part();
				prev.ex = ex;
				add_bin(prev.re, prev.im, prev.ex);
			end
			if (i == RANDOM_BINS / 2)
				add_drain();
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bins.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d bins in %0d-bin blocks, exponents 0 to 15, %0d block summaries;",
			bins_sent, BINS, blocks_seen);
		$display("random stalls on both sides, one long output hold-off and idle pauses.");
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
